/* rtl/tpc_pkg.sv */
// shared types and constants for the triple-redundant transaction controller
package tpc_pkg;

  localparam logic [2:0] OP_ARM     = 3'd0;
  localparam logic [2:0] OP_FIRE    = 3'd1;
  localparam logic [2:0] OP_CONFIRM = 3'd2;
  localparam logic [2:0] OP_SCRUB   = 3'd3;
  localparam logic [2:0] OP_ASSESS  = 3'd4;
  localparam logic [2:0] OP_INJECT  = 3'd5;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_ARMED     = 3'd1;
  localparam logic [2:0] PH_ACTUATING = 3'd2;
  localparam logic [2:0] PH_HALTED    = 3'd6;

  localparam logic [1:0] OUT_NONE      = 2'd0;
  localparam logic [1:0] OUT_COMMITTED = 2'd1;
  localparam logic [1:0] OUT_RETRY     = 2'd2;
  localparam logic [1:0] OUT_HALTED    = 2'd3;

  localparam int unsigned NumReplicas  = 3;
  localparam logic [7:0]  ResetBudget  = 8'd2;
  localparam logic [1:0]  NoMajority   = 2'd3;

  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  transaction;
    logic [31:0] seq_num;
    logic [7:0]  retry;
    logic        valid;
  } rec_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] differ;
    rec_t       value;
  } vote_t;

  typedef struct packed {
    logic [7:0] retry;
    logic [1:0] outcome;
  } tbl_t;

  localparam rec_t IdleRec = '{phase: PH_IDLE, transaction: 8'd0, seq_num: 32'd0,
                               retry: 8'd0, valid: 1'b1};

endpackage

/* rtl/tpc_ram.sv */
// generic simple dual-port ram with registered read
module tpc_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tpc_voter.sv */
// two-of-three majority vote over the replicated controller record
module tpc_voter
  import tpc_pkg::*;
(
  input  rec_t  rep0_i,
  input  rec_t  rep1_i,
  input  rec_t  rep2_i,
  output vote_t vote_o
);

  logic eq01, eq02, eq12;

  assign eq01 = (rep0_i == rep1_i);
  assign eq02 = (rep0_i == rep2_i);
  assign eq12 = (rep1_i == rep2_i);

  always_comb begin
    if (eq01 || eq02) begin
      vote_o.ok     = 1'b1;
      vote_o.value  = rep0_i;
      vote_o.differ = (eq01 && eq02) ? 2'd0 : 2'd1;
    end else if (eq12) begin
      vote_o.ok     = 1'b1;
      vote_o.value  = rep1_i;
      vote_o.differ = 2'd1;
    end else begin
      vote_o.ok     = 1'b0;
      vote_o.value  = IdleRec;
      vote_o.differ = NoMajority;
    end
  end

endmodule

/* rtl/tmr_protected_transaction_controller.sv */
// top level of the triple-redundant transaction controller
//
// requests enter on the in channel (valid/ready) and each request gives exactly one
// result on the out channel (valid/ready). the retry budget is written through the
// cfg channel, which is always ready; write it only while no request is in flight.
// a request is taken in ST_IDLE, while its per-transaction outcome and retry entry
// is read from the table ram; ST_EXEC then votes the three record replicas, updates
// them, writes the table entry back on a confirm and loads the output register.
// no new request is taken until the current one has finished its read-modify-write
// of the table ram. the result sits in an output register, so the next request is
// taken while it waits; a stalled receiver holds the execute step of the following
// request until the output register frees up.
// after reset the block sweeps the table ram to clear it, one entry per cycle,
// with in_ready_o low; replicas reset to idle, halt latch and counters to zero,
// retry budget to two.
module tmr_protected_transaction_controller
  import tpc_pkg::*;
#(
  parameter int unsigned TRANSACTION_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  transaction_i,
  input  logic [31:0] sequence_req_i,
  input  logic        sensor_confirmed_i,
  input  logic [1:0]  replica_index_i,
  input  logic [2:0]  fault_phase_i,
  input  logic [7:0]  fault_retry_i,
  input  logic        fault_valid_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [1:0]  tx_outcome_o,
  output logic        recoverable_o,
  output logic [1:0]  outlier_replicas_o,
  output logic [2:0]  voted_phase_o,
  output logic [7:0]  voted_transaction_o,
  output logic [31:0] voted_sequence_o,
  output logic [7:0]  voted_retry_o,
  output logic        voted_valid_o,
  output logic        halted_flag_o,
  output logic [31:0] commit_count_o,
  output logic [31:0] halt_count_o
);

  localparam int unsigned IdxW = $clog2(TRANSACTION_ENTRIES);
  localparam int unsigned RemW = (IdxW > 8) ? IdxW : 8;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  tx_outcome;
    vote_t       vote;
    logic        halted;
    logic [31:0] commits;
    logic [31:0] halts;
  } res_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c, input logic en);
    logic [31:0] r;
    r = c;
    if (en && (c != '1)) begin
      r = c + 32'd1;
    end
    return r;
  endfunction

  state_e           state_q, state_d;
  logic [IdxW-1:0]  clr_q, clr_d;
  rec_t             rep_q [NumReplicas];
  rec_t             rep_d [NumReplicas];
  logic             halt_q, halt_d;
  logic [31:0]      commits_q, commits_d;
  logic [31:0]      halts_q, halts_d;
  logic [7:0]       budget_q;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic [2:0]       op_q;
  logic [7:0]       tx_q;
  logic [31:0]      seq_q;
  logic             sensor_q;
  logic [1:0]       ridx_q;
  logic [2:0]       fph_q;
  logic [7:0]       fretry_q;
  logic             fvalid_q;
  logic [IdxW-1:0]  idx_q;

  logic [7:0]       rem;
  logic [RemW-1:0]  rem_ext;
  logic [IdxW-1:0]  idx_in;
  logic             in_fire, done;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  tbl_t             ram_wdata, ram_rdata;
  vote_t            vote;
  tbl_t             tbl_new;
  logic             tbl_wr;
  logic             acc;
  logic             halt_a, halt_b, commit_inc;
  rec_t             halt_rec;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign done        = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  // transaction modulo table depth by restoring subtraction
  always_comb begin
    rem = transaction_i;
    for (int k = 7; k >= 0; k--) begin
      if (32'(rem) >= (32'(TRANSACTION_ENTRIES) << k)) begin
        rem = rem - 8'(32'(TRANSACTION_ENTRIES) << k);
      end
    end
    rem_ext = RemW'(rem);
    idx_in  = rem_ext[IdxW-1:0];
  end

  tpc_ram #(
    .WIDTH($bits(tbl_t)),
    .DEPTH(TRANSACTION_ENTRIES)
  ) u_tbl_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_fire),
    .raddr_i(idx_in),
    .rdata_o(ram_rdata)
  );

  tpc_voter u_voter (
    .rep0_i(rep_q[0]),
    .rep1_i(rep_q[1]),
    .rep2_i(rep_q[2]),
    .vote_o(vote)
  );

  always_comb begin
    halt_rec             = IdleRec;
    halt_rec.phase       = PH_HALTED;
    halt_rec.transaction = tx_q;
  end

  always_comb begin
    rep_d      = rep_q;
    tbl_new    = ram_rdata;
    tbl_wr     = 1'b0;
    acc        = 1'b0;
    halt_a     = 1'b0;
    halt_b     = 1'b0;
    commit_inc = 1'b0;

    if (!vote.ok && (op_q == OP_FIRE || op_q == OP_CONFIRM || op_q == OP_SCRUB ||
                     op_q == OP_ASSESS)) begin
      halt_a = 1'b1;
    end

    case (op_q)
      OP_ARM: begin
        if (!halt_q && ram_rdata.outcome != OUT_COMMITTED) begin
          for (int i = 0; i < NumReplicas; i++) begin
            rep_d[i] = '{phase: PH_ARMED, transaction: tx_q, seq_num: seq_q,
                         retry: 8'd0, valid: 1'b1};
          end
          acc = 1'b1;
        end
      end
      OP_FIRE: begin
        if (vote.ok && vote.value.phase == PH_ARMED && vote.value.transaction == tx_q) begin
          for (int i = 0; i < NumReplicas; i++) begin
            rep_d[i]       = vote.value;
            rep_d[i].phase = PH_ACTUATING;
          end
          acc = 1'b1;
        end
      end
      OP_CONFIRM: begin
        tbl_wr = 1'b1;
        if (!vote.ok || vote.value.transaction != tx_q ||
            vote.value.phase != PH_ACTUATING ||
            (!sensor_q && ram_rdata.retry >= budget_q)) begin
          halt_b          = 1'b1;
          tbl_new.outcome = OUT_HALTED;
          for (int i = 0; i < NumReplicas; i++) begin
            rep_d[i] = halt_rec;
          end
        end else if (sensor_q) begin
          commit_inc      = 1'b1;
          tbl_new.outcome = OUT_COMMITTED;
          for (int i = 0; i < NumReplicas; i++) begin
            rep_d[i] = IdleRec;
          end
        end else begin
          tbl_new.retry   = ram_rdata.retry + 8'd1;
          tbl_new.outcome = OUT_RETRY;
          for (int i = 0; i < NumReplicas; i++) begin
            rep_d[i] = IdleRec;
          end
        end
      end
      OP_SCRUB: begin
        if (vote.ok) begin
          for (int i = 0; i < NumReplicas; i++) begin
            rep_d[i] = vote.value;
          end
          acc = 1'b1;
        end
      end
      OP_INJECT: begin
        if (ridx_q < 2'(NumReplicas)) begin
          rep_d[ridx_q] = '{phase: fph_q, transaction: tx_q, seq_num: seq_q,
                            retry: fretry_q, valid: fvalid_q};
        end
      end
      default: begin
      end
    endcase

    halt_d    = halt_q || halt_a || halt_b;
    halts_d   = sat_inc(sat_inc(halts_q, halt_a), halt_b);
    commits_d = sat_inc(commits_q, commit_inc);

    res_d.accepted   = acc;
    res_d.tx_outcome = tbl_new.outcome;
    res_d.vote       = vote;
    res_d.halted     = halt_d;
    res_d.commits    = commits_d;
    res_d.halts      = halts_d;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = tbl_new;
    state_d   = state_q;
    clr_d     = clr_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '{retry: 8'd0, outcome: OUT_NONE};
        clr_d     = clr_q + IdxW'(1);
        if (clr_q == IdxW'(TRANSACTION_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ram_we = done && tbl_wr;
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      halt_q      <= 1'b0;
      commits_q   <= '0;
      halts_q     <= '0;
      budget_q    <= ResetBudget;
      for (int i = 0; i < NumReplicas; i++) begin
        rep_q[i] <= IdleRec;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        budget_q <= cfg_data_i;
      end
      if (done) begin
        halt_q    <= halt_d;
        commits_q <= commits_d;
        halts_q   <= halts_d;
        rep_q     <= rep_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= opcode_i;
      tx_q     <= transaction_i;
      seq_q    <= sequence_req_i;
      sensor_q <= sensor_confirmed_i;
      ridx_q   <= replica_index_i;
      fph_q    <= fault_phase_i;
      fretry_q <= fault_retry_i;
      fvalid_q <= fault_valid_i;
      idx_q    <= idx_in;
    end
    if (done) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign accepted_o             = res_q.accepted;
  assign tx_outcome_o           = res_q.tx_outcome;
  assign recoverable_o          = res_q.vote.ok;
  assign outlier_replicas_o     = res_q.vote.differ;
  assign voted_phase_o          = res_q.vote.value.phase;
  assign voted_transaction_o    = res_q.vote.value.transaction;
  assign voted_sequence_o       = res_q.vote.value.seq_num;
  assign voted_retry_o          = res_q.vote.value.retry;
  assign voted_valid_o          = res_q.vote.value.valid;
  assign halted_flag_o          = res_q.halted;
  assign commit_count_o         = res_q.commits;
  assign halt_count_o           = res_q.halts;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC))
    else $error("accepted request did not move to execute");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!in_ready_o && !out_valid_q))
    else $error("request path active during table clear");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt latch cleared");

  a_commits_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (commits_q >= $past(commits_q)))
    else $error("commit counter went backwards");

  a_result_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_q)
    else $error("finished request produced no result");
`endif

endmodule
